@@ hw/rtl/sgdmf_pkg.sv @@
package sgdmf_pkg;

  // Default sizes of the factor tables.
  localparam int NUM_USERS_DEF   = 1024;
  localparam int NUM_ITEMS_DEF   = 1024;
  localparam int MAX_FACTORS_DEF = 16;

  // Field widths of the request and result channels.
  localparam int MODE_W   = 3;
  localparam int ROW_W    = 10;
  localparam int FAC_W    = 4;
  localparam int VAL_W    = 32;
  localparam int WGT_W    = 24;
  localparam int WERR_W   = 31;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int ACT_W      = 5;
  localparam int RATE_W     = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd2;

  localparam logic [ACT_W-1:0]  ACTIVE_RST = 5'd16;
  localparam logic [RATE_W-1:0] STEP_RST   = 17'd655;
  localparam logic [RATE_W-1:0] LAMBDA_RST = 17'd0;
  localparam logic [RATE_W-1:0] Q_ONE      = 17'h10000;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_WR_USER = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WR_ITEM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRAIN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RD_USER = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RD_ITEM = 3'd4;

  // Shared multiply-accumulate unit.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int ACC_W  = 76;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_32
  } acc_sh_t;

  typedef struct packed {
    acc_op_t op;
    acc_sh_t sh;
  } mac_ctl_t;

endpackage

@@ hw/rtl/sgdmf_in_if.sv @@
interface sgdmf_in_if import sgdmf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  user_index;
  logic [ROW_W-1:0]  item_index;
  logic [FAC_W-1:0]  factor_index;
  logic signed [VAL_W-1:0] value;
  logic [WGT_W-1:0]  weight;

  modport source (
    output valid, mode, user_index, item_index, factor_index, value, weight,
    input  ready
  );
  modport sink (
    input  valid, mode, user_index, item_index, factor_index, value, weight,
    output ready
  );
endinterface

@@ hw/rtl/sgdmf_out_if.sv @@
interface sgdmf_out_if import sgdmf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic signed [VAL_W-1:0] residual;
  logic [WERR_W-1:0]       weighted_error;
  logic                    saturated;

  modport source (
    output valid, read_value, residual, weighted_error, saturated,
    input  ready
  );
  modport sink (
    input  valid, read_value, residual, weighted_error, saturated,
    output ready
  );
endinterface

@@ hw/rtl/sgd_matrix_factorization_unit.sv @@
// Channel  Direction  Payload
// in_if    sink       mode, user_index, item_index, factor_index, value, weight
// out_if   source     read_value, residual, weighted_error, saturated
// cfg_*    write      cfg_index selects active_factors, step_size, regularization
//
// One request at a time. A write passes S_EXEC and S_DONE, a read also S_RDWAIT when
// its indices are in range, before the result is registered. A train request loops over
// the n active factors on the single shared 33x33 multiplier that serves the dot product,
// the error and the five multiplier passes of each element update.
// Reset is synchronous and clears the control state only; the factor tables are
// undefined until written. A new request is taken while the last result still waits.
module sgd_matrix_factorization_unit
  import sgdmf_pkg::*;
#(
  parameter int NUM_USERS   = NUM_USERS_DEF,
  parameter int NUM_ITEMS   = NUM_ITEMS_DEF,
  parameter int MAX_FACTORS = MAX_FACTORS_DEF
)(
  input  logic                  clk,
  input  logic                  rst_n,
  sgdmf_in_if.sink              in_if,
  sgdmf_out_if.source           out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int UDEPTH = NUM_USERS * MAX_FACTORS;
  localparam int IDEPTH = NUM_ITEMS * MAX_FACTORS;
  localparam int UAW    = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
  localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int FW     = $clog2(MAX_FACTORS + 1);

  typedef enum logic [24:0] {
    S_IDLE    = 25'h0000001,
    S_EXEC    = 25'h0000002,
    S_RDWAIT  = 25'h0000004,
    S_DOT_RD  = 25'h0000008,
    S_DOT_MUL = 25'h0000010,
    S_DOT_ACC = 25'h0000020,
    S_RES     = 25'h0000040,
    S_SQ      = 25'h0000080,
    S_E1      = 25'h0000100,
    S_E2      = 25'h0000200,
    S_E3      = 25'h0000400,
    S_E4      = 25'h0000800,
    S_E5      = 25'h0001000,
    S_UPD_RD  = 25'h0002000,
    S_UPD_LD  = 25'h0004000,
    S_UA      = 25'h0008000,
    S_UB1     = 25'h0010000,
    S_UB2     = 25'h0020000,
    S_UB3     = 25'h0040000,
    S_UD      = 25'h0080000,
    S_UC1     = 25'h0100000,
    S_UC2     = 25'h0200000,
    S_UC3     = 25'h0400000,
    S_UN      = 25'h0800000,
    S_DONE    = 25'h1000000
  } state_t;

  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (x < -64'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [ACT_W-1:0]  active_r;
  logic [RATE_W-1:0] step_r;
  logic [RATE_W-1:0] lambda_r;
  logic [RATE_W-1:0] step_eff;
  logic [RATE_W-1:0] lambda_eff;
  logic [FW-1:0]     n_eff;

  // Request registers.
  logic [MODE_W-1:0]       mode_r;
  logic signed [VAL_W-1:0] val_r;
  logic [WGT_W-1:0]        w_r;
  logic [FAC_W-1:0]        fac_r;
  logic [UAW-1:0]          ubase_r;
  logic [IAW-1:0]          ibase_r;
  logic                    u_ok_r, i_ok_r, f_ok_r;
  logic [FW-1:0]           n_r;
  logic [FW-1:0]           f_r;
  logic                    f_last;
  logic                    half_r;

  // Working registers.
  logic signed [52:0] pred_r;
  logic signed [31:0] resid_r;
  logic [46:0]        sq_r;
  logic signed [39:0] wres_r;
  logic [WERR_W-1:0]  werr_r;
  logic               sat_r;
  logic signed [31:0] rd_r;
  logic signed [31:0] uo_r, vo_r, un_r;
  logic signed [33:0] a_r;
  logic signed [56:0] d_r;

  // Result register.
  logic                    out_valid_r;
  logic                    out_free;
  logic signed [VAL_W-1:0] out_rd_r;
  logic signed [VAL_W-1:0] out_resid_r;
  logic [WERR_W-1:0]       out_werr_r;
  logic                    out_sat_r;

  // Factor tables.
  logic [31:0]        u_mem [UDEPTH];
  logic [31:0]        i_mem [IDEPTH];
  logic signed [31:0] u_rdata_r, i_rdata_r;
  logic               u_we, i_we, u_re, i_re;
  logic [UAW-1:0]     u_waddr, u_raddr, u_faddr, u_eaddr;
  logic [IAW-1:0]     i_waddr, i_raddr, i_faddr, i_eaddr;
  logic [31:0]        u_wdata, i_wdata;

  // Shared multiplier.
  mac_ctl_t                 mac_ctl;
  logic signed [MUL_W-1:0]  mac_a, mac_b;
  logic signed [PROD_W-1:0] mac_prod;
  logic signed [ACC_W-1:0]  mac_acc;

  logic signed [31:0] x_sel, y_sel;
  logic signed [63:0] upd_diff, res_diff;
  logic [32:0]        upd_sat, res_sat;

  sgdmf_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .op_a   (mac_a),
    .op_b   (mac_b),
    .prod_r (mac_prod),
    .acc_r  (mac_acc)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
      step_r   <= STEP_RST;
      lambda_r <= LAMBDA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE: active_r <= cfg_wdata[ACT_W-1:0];
        CFG_STEP:   step_r   <= cfg_wdata;
        CFG_LAMBDA: lambda_r <= cfg_wdata;
        default:    active_r <= active_r;
      endcase
    end
  end

  assign step_eff   = (step_r > Q_ONE) ? Q_ONE : step_r;
  assign lambda_eff = (lambda_r > Q_ONE) ? Q_ONE : lambda_r;
  assign n_eff      = (32'(active_r) > MAX_FACTORS) ? FW'(MAX_FACTORS) : FW'(active_r);

  // Addresses for the factor loop and for single-element access.
  assign u_faddr = UAW'(32'(ubase_r) + 32'(f_r));
  assign i_faddr = IAW'(32'(ibase_r) + 32'(f_r));
  assign u_eaddr = UAW'(32'(ubase_r) + 32'(fac_r));
  assign i_eaddr = IAW'(32'(ibase_r) + 32'(fac_r));
  assign f_last  = (FW'(f_r + 1'b1) == n_r);

  // Update operands: own element and partner element.
  assign x_sel = half_r ? vo_r : uo_r;
  assign y_sel = half_r ? un_r : vo_r;

  assign upd_diff = 64'(x_sel) - (64'(mac_acc >>> 16) <<< 1);
  assign upd_sat  = sat32(upd_diff);
  assign res_diff = 64'(val_r) - 64'(pred_r);
  assign res_sat  = sat32(res_diff);

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_if.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (mode_r)
          MODE_RD_USER: state_nxt = (u_ok_r && f_ok_r) ? S_RDWAIT : S_DONE;
          MODE_RD_ITEM: state_nxt = (i_ok_r && f_ok_r) ? S_RDWAIT : S_DONE;
          MODE_TRAIN: begin
            if (u_ok_r && i_ok_r) begin
              state_nxt = (n_r == '0) ? S_RES : S_DOT_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RDWAIT:  state_nxt = S_DONE;
      S_DOT_RD:  state_nxt = S_DOT_MUL;
      S_DOT_MUL: state_nxt = S_DOT_ACC;
      S_DOT_ACC: state_nxt = f_last ? S_RES : S_DOT_RD;
      S_RES:     state_nxt = S_SQ;
      S_SQ:      state_nxt = S_E1;
      S_E1:      state_nxt = S_E2;
      S_E2:      state_nxt = S_E3;
      S_E3:      state_nxt = S_E4;
      S_E4:      state_nxt = S_E5;
      S_E5:      state_nxt = (n_r == '0) ? S_DONE : S_UPD_RD;
      S_UPD_RD:  state_nxt = S_UPD_LD;
      S_UPD_LD:  state_nxt = S_UA;
      S_UA:      state_nxt = S_UB1;
      S_UB1:     state_nxt = S_UB2;
      S_UB2:     state_nxt = S_UB3;
      S_UB3:     state_nxt = S_UD;
      S_UD:      state_nxt = S_UC1;
      S_UC1:     state_nxt = S_UC2;
      S_UC2:     state_nxt = S_UC3;
      S_UC3:     state_nxt = S_UN;
      S_UN: begin
        if (!half_r) begin
          state_nxt = S_UA;
        end else begin
          state_nxt = f_last ? S_DONE : S_UPD_RD;
        end
      end
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Memory ports and multiplier operands for each step.
  always_comb begin
    u_we    = 1'b0;
    i_we    = 1'b0;
    u_re    = 1'b0;
    i_re    = 1'b0;
    u_waddr = u_faddr;
    i_waddr = i_faddr;
    u_raddr = u_faddr;
    i_raddr = i_faddr;
    u_wdata = val_r;
    i_wdata = val_r;
    mac_ctl = '{op: ACC_HOLD, sh: SH_0};
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_r)
      S_EXEC: begin
        unique case (mode_r)
          MODE_WR_USER: begin
            u_we    = u_ok_r && f_ok_r;
            u_waddr = u_eaddr;
          end
          MODE_WR_ITEM: begin
            i_we    = i_ok_r && f_ok_r;
            i_waddr = i_eaddr;
          end
          MODE_RD_USER: begin
            u_re    = u_ok_r && f_ok_r;
            u_raddr = u_eaddr;
          end
          MODE_RD_ITEM: begin
            i_re    = i_ok_r && f_ok_r;
            i_raddr = i_eaddr;
          end
          default: begin
            u_we = 1'b0;
          end
        endcase
      end
      S_DOT_RD, S_UPD_RD: begin
        u_re = 1'b1;
        i_re = 1'b1;
      end
      S_DOT_MUL: begin
        mac_a = {u_rdata_r[31], u_rdata_r};
        mac_b = {i_rdata_r[31], i_rdata_r};
      end
      S_SQ: begin
        mac_a = {resid_r[31], resid_r};
        mac_b = {resid_r[31], resid_r};
      end
      S_E1: begin
        mac_a = {9'b0, w_r};
        mac_b = {resid_r[31], resid_r};
      end
      S_E2: begin
        mac_a = {9'b0, w_r};
        mac_b = {1'b0, sq_r[31:0]};
      end
      S_E3: begin
        mac_ctl = '{op: ACC_LOAD, sh: SH_0};
        mac_a   = {9'b0, w_r};
        mac_b   = {18'b0, sq_r[46:32]};
      end
      S_E4:  mac_ctl = '{op: ACC_ADD, sh: SH_32};
      S_UA: begin
        mac_a = {16'b0, lambda_eff};
        mac_b = {x_sel[31], x_sel};
      end
      S_UB1: begin
        mac_a = {17'b0, wres_r[15:0]};
        mac_b = {y_sel[31], y_sel};
      end
      S_UB2: begin
        mac_ctl = '{op: ACC_LOAD, sh: SH_0};
        mac_a   = {{9{wres_r[39]}}, wres_r[39:16]};
        mac_b   = {y_sel[31], y_sel};
      end
      S_UB3: mac_ctl = '{op: ACC_ADD, sh: SH_16};
      S_UC1: begin
        mac_a = {16'b0, step_eff};
        mac_b = {1'b0, d_r[31:0]};
      end
      S_UC2: begin
        mac_ctl = '{op: ACC_LOAD, sh: SH_0};
        mac_a   = {16'b0, step_eff};
        mac_b   = {{8{d_r[56]}}, d_r[56:32]};
      end
      S_UC3: mac_ctl = '{op: ACC_ADD, sh: SH_32};
      S_UN: begin
        u_we    = !half_r;
        i_we    = half_r;
        u_wdata = upd_sat[31:0];
        i_wdata = upd_sat[31:0];
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  // Factor tables, one synchronous read and one write port each.
  always_ff @(posedge clk) begin
    if (u_we) u_mem[u_waddr] <= u_wdata;
    if (u_re) u_rdata_r <= u_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (i_we) i_mem[i_waddr] <= i_wdata;
    if (i_re) i_rdata_r <= i_mem[i_raddr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          mode_r  <= in_if.mode;
          val_r   <= in_if.value;
          w_r     <= in_if.weight;
          fac_r   <= in_if.factor_index;
          ubase_r <= UAW'(32'(in_if.user_index) * MAX_FACTORS);
          ibase_r <= IAW'(32'(in_if.item_index) * MAX_FACTORS);
          u_ok_r  <= 32'(in_if.user_index) < NUM_USERS;
          i_ok_r  <= 32'(in_if.item_index) < NUM_ITEMS;
          f_ok_r  <= 32'(in_if.factor_index) < MAX_FACTORS;
          n_r     <= n_eff;
          f_r     <= '0;
          half_r  <= 1'b0;
          pred_r  <= '0;
          rd_r    <= '0;
          resid_r <= '0;
          werr_r  <= '0;
          sat_r   <= 1'b0;
        end
      end
      S_RDWAIT: rd_r <= (mode_r == MODE_RD_USER) ? u_rdata_r : i_rdata_r;
      S_DOT_ACC: begin
        pred_r <= pred_r + 53'(mac_prod >>> 16);
        f_r    <= f_last ? '0 : FW'(f_r + 1'b1);
      end
      S_RES: begin
        resid_r <= res_sat[31:0];
        sat_r   <= sat_r | res_sat[32];
      end
      S_E1: sq_r   <= mac_prod[62:16];
      S_E2: wres_r <= mac_prod[55:16];
      S_E5: begin
        // Error above the unsigned Q15.16 range saturates.
        if (|mac_acc[ACC_W-1:47]) begin
          werr_r <= {WERR_W{1'b1}};
          sat_r  <= 1'b1;
        end else begin
          werr_r <= mac_acc[46:16];
        end
      end
      S_UPD_LD: begin
        uo_r <= u_rdata_r;
        vo_r <= i_rdata_r;
      end
      S_UB1: a_r <= 34'(mac_prod >>> 16);
      S_UD:  d_r <= 57'(59'(a_r) - 59'(mac_acc >>> 16));
      S_UN: begin
        sat_r <= sat_r | upd_sat[32];
        if (!half_r) begin
          un_r   <= upd_sat[31:0];
          half_r <= 1'b1;
        end else begin
          half_r <= 1'b0;
          f_r    <= FW'(f_r + 1'b1);
        end
      end
      default: begin
        half_r <= half_r;
      end
    endcase
  end

  // Result register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_rd_r    <= rd_r;
      out_resid_r <= resid_r;
      out_werr_r  <= werr_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.read_value     = out_rd_r;
  assign out_if.residual       = out_resid_r;
  assign out_if.weighted_error = out_werr_r;
  assign out_if.saturated      = out_sat_r;

endmodule

@@ hw/rtl/sgdmf_mac.sv @@
module sgdmf_mac
  import sgdmf_pkg::*;
(
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r,
  output logic signed [ACC_W-1:0]  acc_r
);

  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] prod_sh;

  // The product of the previous cycle, sign-extended and weighted.
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    case (ctl.sh)
      SH_16:   prod_sh = prod_ext <<< 16;
      SH_32:   prod_sh = prod_ext <<< 32;
      default: prod_sh = prod_ext;
    endcase
  end

  // One registered multiply per cycle.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // The accumulator takes the registered product in the cycle after the multiply.
  always_ff @(posedge clk) begin
    case (ctl.op)
      ACC_LOAD: acc_r <= prod_sh;
      ACC_ADD:  acc_r <= acc_r + prod_sh;
      default:  acc_r <= acc_r;
    endcase
  end

endmodule

@@ sim/sgd_matrix_factorization_unit_tb.sv @@
`timescale 1ns / 1ps

module sgd_matrix_factorization_unit_tb;
  import sgdmf_pkg::*;

  localparam longint ERR_LIMIT = 64'd140737488355327;
  localparam longint CYCLE_LIMIT = 64'd4000000;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam int NUM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 210;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [ROW_W-1:0]        user_index;
    logic [ROW_W-1:0]        item_index;
    logic [FAC_W-1:0]        factor_index;
    logic signed [VAL_W-1:0] value;
    logic [WGT_W-1:0]        weight;
  } request_t;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic signed [VAL_W-1:0] residual;
    logic [WERR_W-1:0]       weighted_error;
    logic                    saturated;
  } result_t;

  // Shadow copy of the factor tables and registers, plus the queue of
  // results still owed by the block.
  class factor_scoreboard;
    int      user_tab[NUM_USERS_DEF*MAX_FACTORS_DEF];
    int      item_tab[NUM_ITEMS_DEF*MAX_FACTORS_DEF];
    longint  act_reg = ACTIVE_RST;
    longint  step_reg = STEP_RST;
    longint  lambda_reg = LAMBDA_RST;
    result_t owed_results[$];
    int      errors = 0;

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACTIVE) act_reg = data[ACT_W-1:0];
      else if (idx == CFG_STEP) step_reg = data[RATE_W-1:0];
      else if (idx == CFG_LAMBDA) lambda_reg = data[RATE_W-1:0];
    endfunction

    // Exact product rounded toward minus infinity to Q16.16.
    function longint mul_q16(longint a, longint b);
      logic signed [127:0] wa, wb, p;
      wa = a;
      wb = b;
      p = (wa * wb) >>> 16;
      return p[63:0];
    endfunction

    function longint sat32(longint x, inout bit flag);
      if (x > 64'sd2147483647) begin
        flag = 1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        flag = 1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Apply one accepted request to the shadow state and queue its result.
    function void note_request(request_t r);
      result_t e;
      int ub, ib, n;
      longint lam, step, pred, resid, sq, w, wres, uo, vo, un, vn, d, werr;
      bit sat;
      e = '{default: 0};
      sat = 0;
      ub = r.user_index * MAX_FACTORS_DEF;
      ib = r.item_index * MAX_FACTORS_DEF;
      case (r.mode)
        MODE_WR_USER: user_tab[ub + r.factor_index] = r.value;
        MODE_WR_ITEM: item_tab[ib + r.factor_index] = r.value;
        MODE_RD_USER: e.read_value = user_tab[ub + r.factor_index];
        MODE_RD_ITEM: e.read_value = item_tab[ib + r.factor_index];
        MODE_TRAIN: begin
          n = (act_reg > MAX_FACTORS_DEF) ? MAX_FACTORS_DEF : int'(act_reg);
          lam = (lambda_reg > Q_ONE) ? Q_ONE : lambda_reg;
          step = (step_reg > Q_ONE) ? Q_ONE : step_reg;
          pred = 0;
          for (int f = 0; f < n; f++)
            pred += mul_q16(user_tab[ub + f], item_tab[ib + f]);
          resid = sat32(longint'(r.value) - pred, sat);
          sq = (resid * resid) >>> 16;
          w = longint'({40'd0, r.weight});
          if (w != 0 && sq > ERR_LIMIT / w) begin
            werr = 64'h7FFFFFFF;
            sat = 1;
          end else begin
            werr = (sq * w) >>> 16;
          end
          wres = mul_q16(w, resid);
          for (int f = 0; f < n; f++) begin
            uo = user_tab[ub + f];
            vo = item_tab[ib + f];
            d = mul_q16(lam, uo) - mul_q16(wres, vo);
            un = sat32(uo - 2 * mul_q16(step, d), sat);
            user_tab[ub + f] = int'(un);
            d = mul_q16(lam, vo) - mul_q16(wres, un);
            vn = sat32(vo - 2 * mul_q16(step, d), sat);
            item_tab[ib + f] = int'(vn);
          end
          e.residual = resid[31:0];
          e.weighted_error = werr[WERR_W-1:0];
          e.saturated = sat;
        end
        default: ;
      endcase
      owed_results.push_back(e);
    endfunction

    // Compare one result from the block with the oldest owed result.
    function void check_result(result_t a);
      result_t e;
      if (owed_results.size() == 0) begin
        $error("unexpected result: read_value %0d residual %0d", a.read_value, a.residual);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (a.read_value !== e.read_value) begin
        $error("read_value: expected %0d, actual %0d", e.read_value, a.read_value);
        errors++;
      end
      if (a.residual !== e.residual) begin
        $error("residual: expected %0d, actual %0d", e.residual, a.residual);
        errors++;
      end
      if (a.weighted_error !== e.weighted_error) begin
        $error("weighted_error: expected %0d, actual %0d", e.weighted_error, a.weighted_error);
        errors++;
      end
      if (a.saturated !== e.saturated) begin
        $error("saturated: expected %0b, actual %0b", e.saturated, a.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit quiet;
  longint cycles = 0;
  factor_scoreboard sb = new();

  // Rows that are fully written before any read or train touches them.
  int user_pool[8] = '{0, 1, 2, 5, 511, 512, 1022, 1023};
  int item_pool[8] = '{0, 3, 4, 7, 340, 682, 1021, 1023};

  sgdmf_in_if  in_if();
  sgdmf_out_if out_if();

  sgd_matrix_factorization_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Global cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sgd_matrix_factorization_unit: mismatch");
      $finish;
    end
  end

  // Result side: check accepted results and stall at random unless quiet is set.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result('{out_if.read_value, out_if.residual, out_if.weighted_error,
                        out_if.saturated});
    out_if.ready <= quiet || ($urandom_range(99) >= 9);
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0: return WGT_W'($urandom);
      1: return $urandom_range(1) ? 24'hFFFFFF : 24'h0;
      default: return WGT_W'($urandom_range(131071));
    endcase
  endfunction

  // Send one request, after random idle gaps unless quiet, and wait for its acceptance.
  task automatic send_request(request_t r);
    while (!quiet && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= r.mode;
    in_if.user_index   <= r.user_index;
    in_if.item_index   <= r.item_index;
    in_if.factor_index <= r.factor_index;
    in_if.value        <= r.value;
    in_if.weight       <= r.weight;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
  endtask

  task automatic send_fields(logic [MODE_W-1:0] mode, int u, int i, int f,
                             logic signed [VAL_W-1:0] v, logic [WGT_W-1:0] w);
    request_t r;
    r = '{mode, u[ROW_W-1:0], i[ROW_W-1:0], f[FAC_W-1:0], v, w};
    send_request(r);
  endtask

  // Drop valid, let every owed result drain, then idle a little longer.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(int act, int step, int lam);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACTIVE;
    cfg_wdata <= act[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_config(CFG_ACTIVE, act[CFG_DATA_W-1:0]);
    cfg_index <= CFG_STEP;
    cfg_wdata <= step[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_config(CFG_STEP, step[CFG_DATA_W-1:0]);
    cfg_index <= CFG_LAMBDA;
    cfg_wdata <= lam[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.set_config(CFG_LAMBDA, lam[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  // One random request over the pooled rows.
  task automatic send_random();
    int sel, u, i;
    logic [MODE_W-1:0] mode;
    sel = $urandom_range(99);
    u = user_pool[$urandom_range(7)];
    i = item_pool[$urandom_range(7)];
    if (sel < 50) mode = MODE_TRAIN;
    else if (sel < 60) mode = MODE_WR_USER;
    else if (sel < 70) mode = MODE_WR_ITEM;
    else if (sel < 80) mode = MODE_RD_USER;
    else if (sel < 90) mode = MODE_RD_ITEM;
    else mode = MODE_UNUSED_LO + 3'($urandom_range(2));
    send_fields(mode, u, i, $urandom_range(15), pick_value(), pick_weight());
  endtask

  int phase_act[NUM_PHASES]  = '{16, 1, 0, 4, 31, 8, 2};
  int phase_step[NUM_PHASES] = '{655, 65536, 1000, 0, 131071, 2000, 40000};
  int phase_lam[NUM_PHASES]  = '{0, 65536, 300, 0, 131071, 100, 70000};

  initial begin
    rst_n = 1'b0;
    quiet = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACTIVE;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_WR_USER;
    in_if.user_index = '0;
    in_if.item_index = '0;
    in_if.factor_index = '0;
    in_if.value = '0;
    in_if.weight = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every element of the pooled rows.
    for (int k = 0; k < 8; k++)
      for (int f = 0; f < MAX_FACTORS_DEF; f++) begin
        send_fields(MODE_WR_USER, user_pool[k], 0, f, pick_value(), 0);
        send_fields(MODE_WR_ITEM, 0, item_pool[k], f, pick_value(), 0);
      end

    // Directed: extreme values, read back, train with extremes, unused modes.
    send_fields(MODE_WR_USER, 1023, 0, 15, 32'sh7FFFFFFF, 0);
    send_fields(MODE_WR_ITEM, 0, 1023, 15, 32'sh80000000, 0);
    send_fields(MODE_RD_USER, 1023, 1023, 15, 0, 0);
    send_fields(MODE_RD_ITEM, 1023, 1023, 15, 0, 0);
    send_fields(MODE_RD_USER, 0, 0, 0, 0, 0);
    send_fields(MODE_TRAIN, 1023, 1023, 0, 32'sh7FFFFFFF, 24'hFFFFFF);
    send_fields(MODE_TRAIN, 1023, 1023, 0, 32'sh80000000, 24'hFFFFFF);
    send_fields(MODE_TRAIN, 0, 0, 0, 32'sh00010000, 24'h0);
    send_fields(MODE_TRAIN, 0, 0, 0, 32'sh00020000, 24'h010000);
    send_fields(MODE_RD_USER, 0, 0, 3, 0, 0);
    send_fields(MODE_RD_ITEM, 0, 0, 3, 0, 0);
    send_fields(MODE_UNUSED_LO, 1023, 1023, 15, 32'shFFFFFFFF, 24'hFFFFFF);
    send_fields(MODE_UNUSED_LO + 3'd1, 0, 0, 0, 0, 0);
    send_fields(MODE_UNUSED_LO + 3'd2, 5, 7, 9, 32'sh12345678, 24'h123456);
    send_fields(MODE_WR_USER, 1023, 0, 15, 32'sh00008000, 0);
    send_fields(MODE_WR_ITEM, 0, 1023, 15, -32'sh00008000, 0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_config(phase_act[p], phase_step[p], phase_lam[p]);
      quiet = (p == 5);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 6 && k == ITEMS_PER_PHASE / 2) wait_idle();
        send_random();
      end
    end
    quiet = 0;

    // Drain and finish.
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sgd_matrix_factorization_unit: match");
    end else begin
      $display("sgd_matrix_factorization_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sgd_matrix_factorization_unit.f @@
hw/rtl/sgdmf_pkg.sv
hw/rtl/sgdmf_in_if.sv
hw/rtl/sgdmf_out_if.sv
hw/rtl/sgdmf_mac.sv
hw/rtl/sgd_matrix_factorization_unit.sv
sim/sgd_matrix_factorization_unit_tb.sv
